>>> rtl/pfqs_pkg.sv
`default_nettype none

package pfqs_pkg;

    localparam int unsigned ROUND_W   = 31;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned WEIGHT_W  = 8;
    localparam int unsigned BURST_W   = 16;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned FLOW_ID_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned DEF_QUEUE_DEPTH = 64;
    localparam int unsigned DEF_FLOW_COUNT  = 8;

    localparam longint unsigned ROUNDS_PER_SET = 64;
    localparam longint unsigned SET_COUNT      = 8;
    localparam longint unsigned ROUND_SPAN     = ROUNDS_PER_SET * SET_COUNT;

    localparam logic [ROUND_W-1:0]  ROUND_MAX       = {ROUND_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = WEIGHT_W'(2);
    localparam logic [BURST_W-1:0]  BURST_RESET     = BURST_W'(100);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT     = 3'd0,
        ST_DROP_SPAN  = 3'd1,
        ST_DROP_BURST = 3'd2,
        ST_DROP_FULL  = 3'd3,
        ST_DEQUEUED   = 3'd4,
        ST_EMPTY      = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_ROUND = 2'd0,
        CFG_FLOW_WEIGHT   = 2'd1,
        CFG_BURST_LIMIT   = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CALC,
        FSM_DONE
    } fsm_state_t;

    // Broadcast to every cell of the rank chain.
    typedef struct packed {
        logic               ins;
        logic               deq;
        logic [ROUND_W-1:0] key;
        logic [TAG_W-1:0]   tag;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/pfqs_cell.sv
`default_nettype none

module pfqs_cell
    import pfqs_pkg::*;
(
    input  wire logic               clk,
    input  wire cell_ctl_t          ctl,
    input  wire logic               occupied,
    input  wire logic               left_le,
    input  wire logic [ROUND_W-1:0] left_rank,
    input  wire logic [TAG_W-1:0]   left_tag,
    input  wire logic [ROUND_W-1:0] right_rank,
    input  wire logic [TAG_W-1:0]   right_tag,
    output logic [ROUND_W-1:0]      rank,
    output logic [TAG_W-1:0]        tag,
    output logic                    le
);

    logic [ROUND_W-1:0] rank_reg;
    logic [TAG_W-1:0]   tag_reg;

    // Entries with a rank not above the key stay put, so equal ranks keep arrival order.
    assign le   = occupied && (rank_reg <= ctl.key);
    assign rank = rank_reg;
    assign tag  = tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.deq)
        begin
            rank_reg <= right_rank;
            tag_reg  <= right_tag;
        end
        else if (ctl.ins && !le)
        begin
            if (left_le)
            begin
                rank_reg <= ctl.key;
                tag_reg  <= ctl.tag;
            end
            else
            begin
                rank_reg <= left_rank;
                tag_reg  <= left_tag;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pifo_fair_queue_scheduler_core.sv
`default_nettype none

// Push-in first-out fair queue scheduler.
// Input channel (in_valid / in_stall) carries one item: an enqueue of packet_tag on
// flow_id, or a dequeue of the head packet. Every item yields exactly one result on
// the output channel (out_valid / out_stall): status, out_tag and finish_round.
// Configuration registers (current round, flow weight, burst limit) are written over
// cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// After an item is accepted, the per-flow finish memory is read into a register (FSM_CALC),
// the finish round is formed into fin_reg (FSM_DONE), and a final step checks drops,
// updates the store and loads the output register, which raises out_valid.
// One item is in flight at a time: no new item is accepted until the current one has
// loaded its result into the output register, which then frees the input side.
// The rank store is a chain of QUEUE_DEPTH cells that insert or shift in parallel.
// When out_stall holds a result, a finished item waits in its last step and no new
// item is accepted until the output register frees up.
// Reset clears the store occupancy, the valid bits of all flow finish rounds and the
// configuration registers to their defaults; no clearing pass is needed.

module pifo_fair_queue_scheduler_core
    import pfqs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int unsigned FLOW_COUNT  = DEF_FLOW_COUNT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  opcode,
    input  wire logic [FLOW_ID_W-1:0]  flow_id,
    input  wire logic [TAG_W-1:0]      packet_tag,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [TAG_W-1:0]           out_tag,
    output logic [ROUND_W-1:0]         finish_round,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ROUND_W-1:0]    cfg_data
);

    localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned FLOW_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int unsigned FLOW_IDS = 1 << FLOW_ID_W;

    // Configuration.
    logic [ROUND_W-1:0]  cur_round_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [BURST_W-1:0]  burst_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_round_reg <= '0;
            weight_reg    <= WEIGHT_RESET;
            burst_reg     <= BURST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CURRENT_ROUND: cur_round_reg <= cfg_data;
                CFG_FLOW_WEIGHT:   weight_reg    <= cfg_data[WEIGHT_W-1:0];
                CFG_BURST_LIMIT:   burst_reg     <= cfg_data[BURST_W-1:0];
                default:           ;
            endcase
        end
    end

    // Flow id folding onto the implemented flows.
    logic [FLOW_W-1:0] flow_map [FLOW_IDS];
    logic [FLOW_W-1:0] flow_idx;

    for (genvar g = 0; g < FLOW_IDS; g++)
    begin : g_flow_map
        localparam int unsigned FOLDED = g % FLOW_COUNT;
        assign flow_map[g] = FOLDED[FLOW_W-1:0];
    end

    assign flow_idx = flow_map[flow_id];

    // Control state.
    fsm_state_t state_reg, state_next;
    logic       accept_in;
    logic       commit;
    logic       out_free;
    logic       out_valid_reg;

    assign in_stall  = (state_reg != FSM_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == FSM_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (accept_in) state_next = FSM_CALC;
            FSM_CALC: state_next = FSM_DONE;
            FSM_DONE: if (out_free) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // Item registers.
    logic                 op_reg;
    logic [TAG_W-1:0]     tag_in_reg;
    logic [FLOW_W-1:0]    flow_reg;

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            op_reg     <= opcode;
            tag_in_reg <= packet_tag;
            flow_reg   <= flow_idx;
        end
    end

    // Per-flow last finish round memory with reset valid bits.
    logic [ROUND_W-1:0]    lf_mem [FLOW_COUNT];
    logic [FLOW_COUNT-1:0] lf_vld_reg;
    logic [ROUND_W-1:0]    lf_rd_reg;
    logic                  lf_rd_vld_reg;
    logic                  enq_ok;
    logic [ROUND_W:0]      fin_reg;

    always_ff @(posedge clk)
    begin
        if (accept_in)
            lf_rd_reg <= lf_mem[flow_idx];
        if (commit && enq_ok)
            lf_mem[flow_reg] <= fin_reg[ROUND_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lf_vld_reg    <= '0;
            lf_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept_in)
                lf_rd_vld_reg <= lf_vld_reg[flow_idx];
            if (commit && enq_ok)
                lf_vld_reg[flow_reg] <= 1'b1;
        end
    end

    // Finish round: max(last, current) + weight, one bit wider to catch overflow.
    logic [ROUND_W-1:0] last_fin;
    logic [ROUND_W-1:0] start_round;

    assign last_fin    = lf_rd_vld_reg ? lf_rd_reg : '0;
    assign start_round = (last_fin < cur_round_reg) ? cur_round_reg : last_fin;

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_CALC)
            fin_reg <= {1'b0, start_round} + {{(ROUND_W + 1 - WEIGHT_W){1'b0}}, weight_reg};
    end

    // Drop checks and result selection.
    logic [OCC_W-1:0]   occ_reg;
    logic [ROUND_W:0]   ahead;
    logic [ROUND_W-1:0] head_rank;
    logic [TAG_W-1:0]   head_tag;
    status_t            res_status;
    logic [TAG_W-1:0]   res_tag;
    logic [ROUND_W-1:0] res_fin;
    logic               deq_ok;

    assign ahead = fin_reg - {1'b0, cur_round_reg};

    always_comb
    begin
        res_tag = '0;
        res_fin = fin_reg[ROUND_W-1:0];
        if (op_reg == OP_DEQUEUE)
        begin
            if (occ_reg == '0)
            begin
                res_status = ST_EMPTY;
                res_fin    = '0;
            end
            else
            begin
                res_status = ST_DEQUEUED;
                res_tag    = head_tag;
                res_fin    = head_rank;
            end
        end
        else if (fin_reg[ROUND_W])
        begin
            res_status = ST_DROP_SPAN;
            res_fin    = ROUND_MAX;
        end
        else if (ahead >= (ROUND_W + 1)'(ROUND_SPAN))
            res_status = ST_DROP_SPAN;
        else if (ahead >= {{(ROUND_W + 1 - BURST_W){1'b0}}, burst_reg})
            res_status = ST_DROP_BURST;
        else if (occ_reg >= OCC_W'(QUEUE_DEPTH))
            res_status = ST_DROP_FULL;
        else
            res_status = ST_ACCEPT;
    end

    assign enq_ok = (op_reg == OP_ENQUEUE) && (res_status == ST_ACCEPT);
    assign deq_ok = (op_reg == OP_DEQUEUE) && (occ_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (commit && enq_ok)
            occ_reg <= occ_reg + OCC_W'(1);
        else if (commit && deq_ok)
            occ_reg <= occ_reg - OCC_W'(1);
    end

    // Output register.
    status_t            status_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [ROUND_W-1:0] fin_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg  <= res_status;
            out_tag_reg <= res_tag;
            fin_out_reg <= res_fin;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign finish_round = fin_out_reg;

    // Rank chain.
    cell_ctl_t          cell_ctl;
    logic [ROUND_W-1:0] c_rank [QUEUE_DEPTH];
    logic [TAG_W-1:0]   c_tag  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] c_le;

    assign cell_ctl.ins = commit && enq_ok;
    assign cell_ctl.deq = commit && deq_ok;
    assign cell_ctl.key = fin_reg[ROUND_W-1:0];
    assign cell_ctl.tag = tag_in_reg;

    assign head_rank = c_rank[0];
    assign head_tag  = c_tag[0];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic               occupied;
        logic               left_le;
        logic [ROUND_W-1:0] left_rank;
        logic [TAG_W-1:0]   left_tag;
        logic [ROUND_W-1:0] right_rank;
        logic [TAG_W-1:0]   right_tag;

        assign occupied = (occ_reg > OCC_W'(i));

        if (i == 0)
        begin : g_first
            assign left_le   = 1'b1;
            assign left_rank = '0;
            assign left_tag  = '0;
        end
        else
        begin : g_mid
            assign left_le   = c_le[i-1];
            assign left_rank = c_rank[i-1];
            assign left_tag  = c_tag[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_rank = '0;
            assign right_tag  = '0;
        end
        else
        begin : g_inner
            assign right_rank = c_rank[i+1];
            assign right_tag  = c_tag[i+1];
        end

        pfqs_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .occupied   (occupied),
            .left_le    (left_le),
            .left_rank  (left_rank),
            .left_tag   (left_tag),
            .right_rank (right_rank),
            .right_tag  (right_tag),
            .rank       (c_rank[i]),
            .tag        (c_tag[i]),
            .le         (c_le[i])
        );
    end

endmodule

`default_nettype wire
